// ===== hdl/voxel_ray_traversal_macros.svh =====
// assertion macros shared by the checker
`ifndef VOXEL_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vrt_pkg.sv =====
package vrt_pkg;

  // default widths
  localparam int unsigned VrtFracBits  = 16;
  localparam int unsigned VrtVoxelBits = 16;
  localparam int unsigned VrtTBits     = 48;

  // lookup limit saturation
  localparam int unsigned LimBits = 20;

  // command codes
  localparam logic CmdStart = 1'b0;
  localparam logic CmdResp  = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KindQuery = 2'd0,
    KindHit   = 2'd1,
    KindEnd   = 2'd2
  } kind_e;

endpackage

// ===== hdl/vrt_ifs.sv =====
// input channel: start command or lookup response
interface vrt_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic               voxel_present;
  logic               voxel_is_air;

  modport source (output valid, cmd, origin_x, origin_y, origin_z, end_x, end_y, end_z,
                  voxel_present, voxel_is_air, input ready);
  modport sink   (input valid, cmd, origin_x, origin_y, origin_z, end_x, end_y, end_z,
                  voxel_present, voxel_is_air, output ready);
endinterface

// output channel: query, hit or end
interface vrt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] voxel_x;
  logic signed [15:0] voxel_y;
  logic signed [15:0] voxel_z;

  modport source (output valid, kind, voxel_x, voxel_y, voxel_z, input ready);
  modport sink   (input valid, kind, voxel_x, voxel_y, voxel_z, output ready);
endinterface

// ===== hdl/voxel_ray_traversal.sv =====
// channel | dir | payload                                    | transaction
// in_i    | in  | cmd, origin xyz, end xyz, present, is_air   | valid & ready
// out_o   | out | kind, voxel xyz                             | valid & ready
//
// an air response runs the walk step (axis pick and add), the end test and the output
// load; any other response goes straight to the output load.
// a start item runs the squares, the one-bit-per-cycle shared divider and root unit and
// the limit set-up before the output load; a zero-step axis skips its divisions.
// ready returns in the same cycle that the result appears on out_o.
// reset is asynchronous and leaves the block idle with no walk active.
// in_i.ready is high only while the sequencer is idle; a result waiting on out_o
// stalls the sequencer in its output state, not the walk state.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int unsigned FRAC_BITS  = VrtFracBits,
  parameter int unsigned VOXEL_BITS = VrtVoxelBits,
  parameter int unsigned T_BITS     = VrtTBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vrt_in_if.sink    in_i,
  vrt_out_if.source out_o
);

  localparam int unsigned TF   = T_BITS / 2;
  localparam int unsigned NW   = FRAC_BITS + TF + 1;
  localparam int unsigned DW   = 33;
  localparam int unsigned SUMW = 2 * DW + 2;
  localparam int unsigned SPW  = SUMW - 2 * FRAC_BITS + 1;
  localparam int unsigned H    = (SPW + 1) / 2;
  localparam int unsigned CW   = $clog2(NW + 1);
  localparam int unsigned RCW  = $clog2(H + 1);
  localparam int unsigned LW   = (H + 3 > LimBits) ? H + 3 : LimBits;
  localparam int unsigned QXW  = NW + T_BITS;

  localparam logic [T_BITS-1:0]  TMax   = {T_BITS{1'b1}};
  localparam logic [T_BITS-1:0]  TOne   = T_BITS'(1) << TF;
  localparam logic [LimBits-1:0] LimMax = {LimBits{1'b1}};

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StSqr   = 10'b0000000010,
    StDivLd = 10'b0000000100,
    StDiv   = 10'b0000001000,
    StSqLd  = 10'b0000010000,
    StSqrt  = 10'b0000100000,
    StFin   = 10'b0001000000,
    StStep  = 10'b0010000000,
    StCheck = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // walk state
  logic        [DW-1:0]         ad_q   [3];
  logic        [FRAC_BITS:0]    dist_q [3];
  logic signed [1:0]            dir_q  [3];
  logic signed [VOXEL_BITS-1:0] vox_q  [3];
  logic        [T_BITS-1:0]     tstep_q[3];
  logic        [T_BITS-1:0]     tnext_q[3];
  logic        [LimBits-1:0]    done_q, limit_q;
  logic                         active_q;

  // shared unit state
  logic [SUMW-1:0] sum_q;
  logic [1:0]      axis_q;
  logic            op_q;
  logic [CW-1:0]   bit_q;
  logic [RCW-1:0]  rcnt_q;
  logic [NW-1:0]   num_q, quo_q;
  logic [DW:0]     rem_q;
  logic [2*H-1:0]  sqv_q;
  logic [H-1:0]    root_q;
  logic [H+1:0]    srem_q;

  // pending result
  kind_e res_kind_q;
  logic  res_zero_q;

  // output register
  logic               out_valid_q;
  kind_e              out_kind_q;
  logic signed [15:0] out_vox_q[3];

  logic in_acc;
  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;

  // start decode per axis
  logic signed [31:0]        org[3], fin[3], shv[3];
  logic signed [32:0]        dlt[3];
  logic        [DW-1:0]      ad_w[3];
  logic signed [1:0]         dir_w[3];
  logic        [FRAC_BITS:0] dist_w[3];

  assign org[0] = in_i.origin_x;
  assign org[1] = in_i.origin_y;
  assign org[2] = in_i.origin_z;
  assign fin[0] = in_i.end_x;
  assign fin[1] = in_i.end_y;
  assign fin[2] = in_i.end_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i]  = 33'(fin[i]) - 33'(org[i]);
      ad_w[i] = dlt[i][32] ? DW'(-dlt[i]) : DW'(dlt[i]);
      if (dlt[i] == 33'sd0) begin
        dir_w[i] = 2'sd0;
      end else if (dlt[i][32]) begin
        dir_w[i] = -2'sd1;
      end else begin
        dir_w[i] = 2'sd1;
      end
      shv[i] = org[i] >>> FRAC_BITS;
      if (dir_w[i] == 2'sd1) begin
        dist_w[i] = (FRAC_BITS+1)'(1) << FRAC_BITS;
        dist_w[i] = dist_w[i] - {1'b0, org[i][FRAC_BITS-1:0]};
      end else begin
        dist_w[i] = {1'b0, org[i][FRAC_BITS-1:0]};
      end
    end
  end

  // divider step
  logic [DW:0]         rem_sh;
  logic                div_ge;
  logic [NW-1:0]       quo_fin;
  logic [QXW-1:0]      quo_x;
  logic [T_BITS-1:0]   quo_t;
  logic [2*DW-1:0]     sq_w;

  assign rem_sh  = {rem_q[DW-1:0], num_q[NW-1]};
  assign div_ge  = rem_sh >= {1'b0, ad_q[axis_q]};
  assign quo_fin = {quo_q[NW-2:0], div_ge};
  assign quo_x   = QXW'(quo_fin);
  assign quo_t   = (quo_x > QXW'(TMax)) ? TMax : quo_x[T_BITS-1:0];
  assign sq_w    = ad_q[axis_q] * ad_q[axis_q];

  // root step
  logic [SPW-1:0] sp_w;
  logic [H+1:0]   srem_sh, trial;
  logic           sq_ge;
  logic [H:0]     n_w;
  logic [LW-1:0]  n3_w;
  logic [LimBits-1:0] lim_w;

  assign sp_w    = SPW'(sum_q >> (2 * FRAC_BITS)) + SPW'(|sum_q[2*FRAC_BITS-1:0]);
  assign srem_sh = {srem_q[H-1:0], sqv_q[2*H-1:2*H-2]};
  assign trial   = {root_q, 2'b01};
  assign sq_ge   = srem_sh >= trial;
  assign n_w     = (H+1)'(root_q) + (H+1)'(srem_q != '0);
  assign n3_w    = LW'(n_w) * LW'(3);
  assign lim_w   = (n3_w > LW'(LimMax)) ? LimMax : n3_w[LimBits-1:0];

  // walk step: axis pick, saturating add, end test
  logic [1:0]        ax_w;
  logic [T_BITS:0]   tsum_w;
  logic [T_BITS-1:0] tnew_w;
  logic              walk_end;

  always_comb begin
    if (tnext_q[0] < tnext_q[1]) begin
      ax_w = (tnext_q[0] < tnext_q[2]) ? 2'd0 : 2'd2;
    end else begin
      ax_w = (tnext_q[1] < tnext_q[2]) ? 2'd1 : 2'd2;
    end
  end

  assign tsum_w   = {1'b0, tnext_q[ax_w]} + {1'b0, tstep_q[ax_w]};
  assign tnew_w   = tsum_w[T_BITS] ? TMax : tsum_w[T_BITS-1:0];
  assign walk_end = ((tnext_q[0] > TOne) && (tnext_q[1] > TOne) && (tnext_q[2] > TOne))
                    || (done_q >= limit_q);

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.cmd == CmdStart) begin
            state_d = StSqr;
          end else if (active_q && in_i.voxel_present && in_i.voxel_is_air) begin
            state_d = StStep;
          end else begin
            state_d = StOut;
          end
        end
      end
      StSqr:   if (axis_q == 2'd2) state_d = StDivLd;
      StDivLd: begin
        if (op_q == 1'b0 && ad_q[axis_q] == '0) begin
          state_d = (axis_q == 2'd2) ? StSqLd : StDivLd;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (bit_q == CW'(NW - 1)) begin
          state_d = (op_q && axis_q == 2'd2) ? StSqLd : StDivLd;
        end
      end
      StSqLd:  state_d = StSqrt;
      StSqrt:  if (rcnt_q == RCW'(H - 1)) state_d = StFin;
      StFin:   state_d = StOut;
      StStep:  state_d = StCheck;
      StCheck: state_d = StOut;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      axis_q      <= '0;
      op_q        <= 1'b0;
      bit_q       <= '0;
      rcnt_q      <= '0;
      done_q      <= '0;
      limit_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          axis_q <= '0;
          op_q   <= 1'b0;
          if (in_acc && in_i.cmd == CmdResp && active_q &&
              !(in_i.voxel_present && in_i.voxel_is_air)) begin
            active_q <= 1'b0;
          end
        end
        StSqr:   axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        StDivLd: begin
          bit_q <= '0;
          if (op_q == 1'b0 && ad_q[axis_q] == '0) begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StDiv: begin
          bit_q <= bit_q + CW'(1);
          if (bit_q == CW'(NW - 1)) begin
            op_q <= !op_q;
            if (op_q) axis_q <= axis_q + 2'd1;
          end
        end
        StSqLd:  rcnt_q <= '0;
        StSqrt:  rcnt_q <= rcnt_q + RCW'(1);
        StFin: begin
          limit_q  <= lim_w;
          done_q   <= LimBits'(1);
          active_q <= (lim_w != '0);
        end
        StCheck: begin
          if (walk_end) begin
            active_q <= 1'b0;
          end else begin
            done_q <= done_q + LimBits'(1);
          end
        end
        default: ;
      endcase
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_zero_q <= (in_i.cmd == CmdResp) && !active_q;
          if (in_i.cmd == CmdStart) begin
            sum_q <= '0;
            for (int i = 0; i < 3; i++) begin
              ad_q[i]   <= ad_w[i];
              dir_q[i]  <= dir_w[i];
              dist_q[i] <= dist_w[i];
              vox_q[i]  <= shv[i][VOXEL_BITS-1:0];
            end
          end else if (!active_q) begin
            res_kind_q <= KindEnd;
          end else if (!in_i.voxel_present) begin
            res_kind_q <= KindEnd;
          end else if (!in_i.voxel_is_air) begin
            res_kind_q <= KindHit;
          end
        end
      end
      StSqr:   sum_q <= sum_q + SUMW'(sq_w);
      StDivLd: begin
        rem_q <= '0;
        quo_q <= '0;
        if (op_q == 1'b0 && ad_q[axis_q] == '0) begin
          tstep_q[axis_q] <= TMax;
          tnext_q[axis_q] <= TMax;
        end else if (op_q == 1'b0) begin
          num_q <= NW'(1) << (FRAC_BITS + TF);
        end else begin
          num_q <= NW'(dist_q[axis_q]) << TF;
        end
      end
      StDiv: begin
        rem_q <= div_ge ? rem_sh - {1'b0, ad_q[axis_q]} : rem_sh;
        quo_q <= quo_fin;
        num_q <= num_q << 1;
        if (bit_q == CW'(NW - 1)) begin
          if (op_q) tnext_q[axis_q] <= quo_t;
          else      tstep_q[axis_q] <= quo_t;
        end
      end
      StSqLd: begin
        sqv_q  <= (2*H)'(sp_w);
        root_q <= '0;
        srem_q <= '0;
      end
      StSqrt: begin
        sqv_q  <= sqv_q << 2;
        srem_q <= sq_ge ? srem_sh - trial : srem_sh;
        root_q <= {root_q[H-2:0], sq_ge};
      end
      StFin:   res_kind_q <= (lim_w == '0) ? KindEnd : KindQuery;
      StStep: begin
        tnext_q[ax_w] <= tnew_w;
        vox_q[ax_w]   <= vox_q[ax_w] + VOXEL_BITS'(dir_q[ax_w]);
      end
      StCheck: res_kind_q <= walk_end ? KindEnd : KindQuery;
      StOut: begin
        if (out_free) begin
          out_kind_q <= res_kind_q;
          for (int i = 0; i < 3; i++) begin
            out_vox_q[i] <= res_zero_q ? 16'sd0 : 16'(vox_q[i]);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.kind    = out_kind_q;
  assign out_o.voxel_x = out_vox_q[0];
  assign out_o.voxel_y = out_vox_q[1];
  assign out_o.voxel_z = out_vox_q[2];

endmodule

// ===== hdl/vrt_checker.sv =====
`include "voxel_ray_traversal_macros.svh"

module vrt_checker import vrt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i
);

  logic in_txn;
  assign in_txn = in_valid_i && in_ready_i;

  // a stalled result stays offered
  `VRT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // the sequencer is busy right after taking a transaction
  `VRT_ASSERT_NEXT(a_busy, in_txn, !in_ready_i, "ready right after accept")

  // no result appears in the cycle after an accept
  `VRT_ASSERT_NEXT(a_latency, in_txn, !$rose(out_valid_i), "result too early")

  // only defined kinds leave the block
  `VRT_ASSERT_SAME(a_kind, out_valid_i,
    out_kind_i == KindQuery || out_kind_i == KindHit || out_kind_i == KindEnd,
    "bad kind")

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind)
);

// ===== dv/tb_voxel_ray_traversal.sv =====
module tb_voxel_ray_traversal;
  import vrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TFrac = VrtTBits / 2;
  localparam logic [47:0] TMax  = {48{1'b1}};
  localparam logic [47:0] TOne  = 48'd1 << TFrac;
  localparam int unsigned LimMax = (1 << LimBits) - 1;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
  } voxel_result_t;

  typedef struct {
    logic               cmd;
    logic signed [31:0] org[3];
    logic signed [31:0] fin[3];
    logic               present;
    logic               is_air;
  } ray_item_t;

  // walk predictor and expected result store
  class walk_scoreboard;
    bit                 walking;
    logic signed [15:0] voxel[3];
    int                 dir[3];
    logic [47:0]        tstep[3];
    logic [47:0]        tnext[3];
    int unsigned        done_cnt;
    int unsigned        limit;
    voxel_result_t      pending[$];
    int                 errors;
    int                 checked;
    int                 hits;
    int                 starts;

    function void clear();
      walking = 0;
      for (int i = 0; i < 3; i++) begin
        voxel[i] = 0; dir[i] = 0; tstep[i] = 0; tnext[i] = 0;
      end
      done_cnt = 0; limit = 0;
    endfunction

    function voxel_result_t make(kind_e k, bit with_voxel);
      voxel_result_t r;
      r.kind = k;
      r.vx = with_voxel ? voxel[0] : 16'd0;
      r.vy = with_voxel ? voxel[1] : 16'd0;
      r.vz = with_voxel ? voxel[2] : 16'd0;
      return r;
    endfunction

    // floor, signs, t setup and lookup limit
    function void begin_ray(ray_item_t it);
      logic signed [33:0] d;
      logic [32:0]        ad;
      logic [15:0]        fo;
      logic [16:0]        frac_dist;
      logic [127:0]       q;
      logic [127:0]       sum;
      logic [127:0]       sq;
      logic [63:0]        lo, hi, mid;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        d = 34'(it.fin[i]) - 34'(it.org[i]);
        voxel[i] = it.org[i][31:16];
        fo = it.org[i][15:0];
        ad = d < 0 ? 33'(-d) : 33'(d);
        dir[i] = d > 0 ? 1 : (d < 0 ? -1 : 0);
        if (ad == 0) begin
          tstep[i] = TMax; tnext[i] = TMax;
        end else begin
          frac_dist = dir[i] > 0 ? 17'h10000 - fo : {1'b0, fo};
          q = (128'd1 << (16 + TFrac)) / ad;
          tstep[i] = q > TMax ? TMax : q[47:0];
          q = (128'(frac_dist) << TFrac) / ad;
          tnext[i] = q > TMax ? TMax : q[47:0];
        end
        sum += 128'(ad) * 128'(ad);
      end
      lo = 0; hi = 64'd1 << 26;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        sq = 128'(mid << 16) * 128'(mid << 16);
        if (sq >= sum) hi = mid; else lo = mid + 1;
      end
      limit = (3 * lo > LimMax) ? LimMax : 32'(3 * lo);
      done_cnt = 0;
    endfunction

    function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = a + b;
      return s[48] ? TMax : s[47:0];
    endfunction

    function void note_input(ray_item_t it);
      int ax;
      if (it.cmd == CmdStart) begin
        starts++;
        begin_ray(it);
        if (limit == 0) begin
          walking = 0; pending.push_back(make(KindEnd, 1)); return;
        end
        walking = 1; done_cnt = 1;
        pending.push_back(make(KindQuery, 1)); return;
      end
      if (!walking) begin
        pending.push_back(make(KindEnd, 0)); return;
      end
      if (!it.present) begin
        walking = 0; pending.push_back(make(KindEnd, 1)); return;
      end
      if (!it.is_air) begin
        walking = 0; hits++; pending.push_back(make(KindHit, 1)); return;
      end
      if (tnext[0] < tnext[1]) ax = tnext[0] < tnext[2] ? 0 : 2;
      else ax = tnext[1] < tnext[2] ? 1 : 2;
      voxel[ax] = voxel[ax] + 16'(dir[ax]);
      tnext[ax] = sat_add(tnext[ax], tstep[ax]);
      if ((tnext[0] > TOne && tnext[1] > TOne && tnext[2] > TOne) || done_cnt >= limit) begin
        walking = 0; pending.push_back(make(KindEnd, 1)); return;
      end
      done_cnt++;
      pending.push_back(make(KindQuery, 1));
    endfunction

    function void check_result(voxel_result_t got);
      voxel_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d voxel=%h %h %h", $realtime, got.kind,
                 got.vx, got.vy, got.vz);
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) begin
        errors++;
        $display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind, got.kind);
      end
      if (got.vx !== exp_r.vx) begin
        errors++;
        $display("%0t: voxel_x expected %h actual %h", $realtime, exp_r.vx, got.vx);
      end
      if (got.vy !== exp_r.vy) begin
        errors++;
        $display("%0t: voxel_y expected %h actual %h", $realtime, exp_r.vy, got.vy);
      end
      if (got.vz !== exp_r.vz) begin
        errors++;
        $display("%0t: voxel_z expected %h actual %h", $realtime, exp_r.vz, got.vz);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  vrt_in_if  in_if ();
  vrt_out_if out_if ();

  voxel_ray_traversal u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  walk_scoreboard sb = new();
  bit             stim_done;
  bit             hold_out;
  int             item_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #200ms;
    $display("FAIL voxel_ray_traversal");
    $finish;
  end

  // send one item, waiting the given gap first; valid stays up when the gap is zero
  task automatic send_item(ray_item_t it, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= it.cmd;
    in_if.origin_x      <= it.org[0];
    in_if.origin_y      <= it.org[1];
    in_if.origin_z      <= it.org[2];
    in_if.end_x         <= it.fin[0];
    in_if.end_y         <= it.fin[1];
    in_if.end_z         <= it.fin[2];
    in_if.voxel_present <= it.present;
    in_if.voxel_is_air  <= it.is_air;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    item_cnt++;
    @(negedge clk_i);
  endtask

  function automatic ray_item_t start_item(logic signed [31:0] o0, o1, o2, e0, e1, e2);
    ray_item_t it;
    it.cmd = CmdStart;
    it.org[0] = o0; it.org[1] = o1; it.org[2] = o2;
    it.fin[0] = e0; it.fin[1] = e1; it.fin[2] = e2;
    it.present = $urandom_range(0, 1);
    it.is_air = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic ray_item_t resp_item(bit present, bit is_air);
    ray_item_t it;
    it.cmd = CmdResp;
    for (int i = 0; i < 3; i++) begin
      it.org[i] = $urandom; it.fin[i] = $urandom;
    end
    it.present = present;
    it.is_air = is_air;
    return it;
  endfunction

  // random short segment near a random point
  function automatic ray_item_t short_ray();
    logic signed [31:0] o[3];
    logic signed [31:0] e[3];
    int span;
    span = $urandom_range(0, 3) == 0 ? 32'h0008_0000 : 32'h0002_0000;
    for (int i = 0; i < 3; i++) begin
      o[i] = $urandom;
      e[i] = $urandom_range(0, 5) == 0 ? o[i]
           : o[i] + $signed($urandom_range(0, 2 * span)) - span;
    end
    return start_item(o[0], o[1], o[2], e[0], e[1], e[2]);
  endfunction

  function automatic int gap_draw();
    return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
  endfunction

  // output sink with random stalls
  initial begin
    voxel_result_t r;
    int            wait_cnt;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_cnt = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
      if (wait_cnt > 0 || hold_out) begin
        out_if.ready <= 1'b0;
        repeat (wait_cnt) @(negedge clk_i);
        while (hold_out) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      r.kind = kind_e'(out_if.kind);
      r.vx = out_if.voxel_x; r.vy = out_if.voxel_y; r.vz = out_if.voxel_z;
      sb.check_result(r);
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    hold_out = 1'b0;
    wait (item_cnt >= 60);
    @(negedge clk_i);
    hold_out = 1'b1;
    repeat (2000) @(negedge clk_i);
    hold_out = 1'b0;
  end

  // stimulus
  initial begin
    int walk_len;
    int drain;
    in_if.valid = 1'b0;
    in_if.cmd = CmdStart;
    in_if.origin_x = '0; in_if.origin_y = '0; in_if.origin_z = '0;
    in_if.end_x = '0; in_if.end_y = '0; in_if.end_z = '0;
    in_if.voxel_present = 1'b0; in_if.voxel_is_air = 1'b0;
    sb.clear();
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle response, zero length, extremes, ties
    send_item(resp_item(1, 1), 0);
    send_item(start_item(32'h0001_8000, 0, 0, 32'h0001_8000, 0, 0), 2);
    send_item(start_item(0, 0, 0, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000), 0);
    send_item(resp_item(1, 1), 0);
    send_item(resp_item(1, 1), 1);
    send_item(resp_item(1, 1), 0);
    send_item(resp_item(1, 0), 3);
    send_item(start_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0);
    send_item(resp_item(1, 1), 0);
    send_item(start_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_0000, 32'h7fff_ffff, 32'h7ffe_8000), 0);
    send_item(resp_item(1, 1), 0);
    send_item(resp_item(0, 1), 0);
    send_item(start_item(32'hffff_0001, 32'h0000_ffff, 32'h8000_0000,
                         32'hfffe_0001, 32'h0001_ffff, 32'h8000_0001), 0);
    send_item(resp_item(1, 1), 0);
    send_item(resp_item(1, 1), 0);
    send_item(start_item(0, 0, 0, 32'h0000_0001, 0, 0), 0);
    send_item(resp_item(1, 1), 0);
    send_item(resp_item(1, 1), 0);
    send_item(resp_item(0, 0), 0);

    // random walks: mostly well-formed, some noise
    while (item_cnt < 650) begin
      send_item(short_ray(), gap_draw());
      walk_len = $urandom_range(0, 12);
      for (int k = 0; k < walk_len; k++) begin
        case ($urandom_range(0, 19))
          0: send_item(resp_item(0, $urandom_range(0, 1)), gap_draw());
          1: send_item(resp_item(1, 0), gap_draw());
          default: send_item(resp_item(1, 1), gap_draw());
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        send_item(resp_item($urandom_range(0, 1), $urandom_range(0, 1)), gap_draw());
    end
    in_if.valid <= 1'b0;

    // drain
    drain = 0;
    while (sb.pending.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (300) @(posedge clk_i);
    $display("covered %0d items, %0d rays, %0d results checked, %0d hits", item_cnt,
             sb.starts, sb.checked, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS voxel_ray_traversal");
    end else begin
      $display("FAIL voxel_ray_traversal");
    end
    $finish;
  end
endmodule
